>>> src/can_tx_slot_retry_scheduler_defines.svh
// Assertion macros for the transmit slot scheduler port checker.
`ifndef CAN_TX_SLOT_RETRY_SCHEDULER_DEFINES_SVH
`define CAN_TX_SLOT_RETRY_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CTS_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CTS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/cts_pkg.sv
// Types and constants for the CAN transmit slot retry scheduler.
package cts_pkg;

    localparam int IDENT_W = 11;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 6;

    localparam logic [CNT_W-1:0] MAX_RES = 6'd32;
    localparam logic [CNT_W-1:0] MAX_SLOTS = 6'd32;

    localparam logic [1:0] CMD_SETUP = 2'd0;
    localparam logic [1:0] CMD_SEND  = 2'd1;
    localparam logic [1:0] CMD_RETRY = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_QUEUED = 2'd1;
    localparam logic [1:0] ST_OVF    = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    typedef struct packed {
        logic               frame_valid;
        logic [SLOT_W-1:0]  out_slot;
        logic [IDENT_W-1:0] out_ident;
        logic [1:0]         status;
        logic [CNT_W-1:0]   pending_total;
        logic               inhibit_flag;
        logic               overflow_flag;
        logic               late_flag;
        logic               last;
    } res_t;

endpackage

>>> src/can_tx_slot_retry_scheduler.sv
// Top level: CAN transmit slot table with pending marks and a one-slot-per-cycle retry walk (held by stalls).
//
//  channel   direction  handshake               payload
//  item      in         item_valid/item_stall   command slot frame_ident sync_mark queue_free
//  result    out        res_valid/res_stall     frame_valid out_slot out_ident status ...
//  config    in         cfg_wr_en               cfg_wr_data (slots_in_use)
//
// Set up and bad/overflow/queued sends go straight to S_FINISH; an immediate send passes
// S_RD (ident RAM read is registered), S_FETCH and S_FINISH. Retry and clear walk the slot
// table one slot per cycle, retry passing through S_FETCH for each frame handed out, where a
// stalled result can hold it.
// Reset is asynchronous, no clearing pass: per-slot written bits mask the ident RAM.
// A stalled result holds the walk only when a further result must be moved out.
module can_tx_slot_retry_scheduler #(
    parameter int TX_SLOTS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cts_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [1:0]                  command,
    input  logic [cts_pkg::SLOT_W-1:0]  slot,
    input  logic [cts_pkg::IDENT_W-1:0] frame_ident,
    input  logic                        sync_mark,
    input  logic [cts_pkg::CNT_W-1:0]   queue_free,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        frame_valid,
    output logic [cts_pkg::SLOT_W-1:0]  out_slot,
    output logic [cts_pkg::IDENT_W-1:0] out_ident,
    output logic [1:0]                  status,
    output logic [cts_pkg::CNT_W-1:0]   pending_total,
    output logic                        inhibit_flag,
    output logic                        overflow_flag,
    output logic                        late_flag,
    output logic                        last
);
    import cts_pkg::*;

    // slot field is 5 bits, so no more than 32 slots are ever reachable
    localparam int DEPTH = (TX_SLOTS < 32) ? TX_SLOTS : 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_WALK, S_FETCH, S_CLEAR, S_FINISH
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     slots_cfg_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [CNT_W-1:0]     qfree_reg;
    logic [1:0]           cmd_reg;
    logic [1:0]           status_reg;
    logic                 dropped_reg;
    logic [CNT_W-1:0]     pcount_reg;
    logic                 inhibit_reg;
    logic                 nothing_sent_reg;
    logic                 ovf_reg;
    logic                 late_reg;
    logic [DEPTH-1:0]     pend_reg;
    logic [DEPTH-1:0]     sync_reg;
    logic [DEPTH-1:0]     written_reg;
    res_t                 hold_reg;
    logic                 hold_valid_reg;
    res_t                 out_reg;
    logic                 out_valid_reg;

    logic [IDENT_W-1:0]   ident_mem [DEPTH];
    logic [IDENT_W-1:0]   rd_data_reg;

    logic [CNT_W-1:0]     n_used;
    logic                 accept;
    logic                 slot_ok;
    logic [IDX_W-1:0]     in_idx;
    logic [IDX_W-1:0]     cur_idx;
    logic                 out_free;
    logic                 out_load;
    logic                 walk_done;
    logic                 mem_we;
    res_t                 frame_res;
    res_t                 plain_res;
    res_t                 final_res;

    assign n_used   = (slots_cfg_reg > DEPTH_C) ? DEPTH_C : slots_cfg_reg;
    assign accept   = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign in_idx   = slot[IDX_W-1:0];
    assign cur_idx  = idx_reg[IDX_W-1:0];
    assign slot_ok  = ({1'b0, slot} < n_used);
    assign out_free = !out_valid_reg || !res_stall;
    assign out_load = ((state_reg == S_FETCH) && hold_valid_reg && out_free) ||
                      ((state_reg == S_FINISH) && out_free);
    assign mem_we   = accept && (command == CMD_SETUP) && slot_ok;

    assign walk_done = (idx_reg >= n_used) || (pcount_reg == '0) ||
                       (pend_reg[cur_idx] && ((qfree_reg == '0) || (k_reg >= MAX_RES)));

    always_comb
    begin
        frame_res.frame_valid   = 1'b1;
        frame_res.out_slot      = SLOT_W'(idx_reg);
        frame_res.out_ident     = written_reg[cur_idx] ? rd_data_reg : '0;
        frame_res.status        = ST_DONE;
        frame_res.pending_total = (cmd_reg == CMD_RETRY) ? (pcount_reg - CNT_W'(1))
                                                         : pcount_reg;
        frame_res.inhibit_flag  = sync_reg[cur_idx];
        frame_res.overflow_flag = ovf_reg;
        frame_res.late_flag     = late_reg;
        frame_res.last          = 1'b0;

        plain_res.frame_valid   = 1'b0;
        plain_res.out_slot      = '0;
        plain_res.out_ident     = '0;
        plain_res.status        = status_reg;
        plain_res.pending_total = pcount_reg;
        plain_res.inhibit_flag  = inhibit_reg;
        plain_res.overflow_flag = ovf_reg;
        plain_res.late_flag     = late_reg;
        plain_res.last          = 1'b1;

        final_res      = hold_reg;
        final_res.last = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ident_mem[in_idx] <= frame_ident;
        end
        rd_data_reg <= ident_mem[cur_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slots_cfg_reg    <= MAX_SLOTS;
            idx_reg          <= '0;
            k_reg            <= '0;
            qfree_reg        <= '0;
            cmd_reg          <= CMD_SETUP;
            status_reg       <= ST_DONE;
            dropped_reg      <= 1'b0;
            pcount_reg       <= '0;
            inhibit_reg      <= 1'b0;
            nothing_sent_reg <= 1'b1;
            ovf_reg          <= 1'b0;
            late_reg         <= 1'b0;
            pend_reg         <= '0;
            sync_reg         <= '0;
            written_reg      <= '0;
            hold_reg         <= '0;
            hold_valid_reg   <= 1'b0;
            out_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                slots_cfg_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !res_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= command;
                        idx_reg    <= (command == CMD_SEND) ? {1'b0, slot} : '0;
                        k_reg      <= '0;
                        qfree_reg  <= queue_free;
                        hold_valid_reg <= 1'b0;
                        case (command)
                            CMD_SETUP:
                            begin
                                state_reg <= S_FINISH;
                                if (!slot_ok)
                                begin
                                    status_reg <= ST_BAD;
                                end
                                else
                                begin
                                    status_reg          <= ST_DONE;
                                    sync_reg[in_idx]    <= sync_mark;
                                    written_reg[in_idx] <= 1'b1;
                                    pend_reg[in_idx]    <= 1'b0;
                                    if (pend_reg[in_idx] && (pcount_reg != '0))
                                    begin
                                        pcount_reg <= pcount_reg - CNT_W'(1);
                                    end
                                end
                            end
                            CMD_SEND:
                            begin
                                if (!slot_ok)
                                begin
                                    status_reg <= ST_BAD;
                                    state_reg  <= S_FINISH;
                                end
                                else if (pend_reg[in_idx])
                                begin
                                    if (!nothing_sent_reg)
                                    begin
                                        ovf_reg <= 1'b1;
                                    end
                                    status_reg <= ST_OVF;
                                    state_reg  <= S_FINISH;
                                end
                                else if ((pcount_reg == '0) && (queue_free != '0))
                                begin
                                    status_reg <= ST_DONE;
                                    state_reg  <= S_RD;
                                end
                                else
                                begin
                                    pend_reg[in_idx] <= 1'b1;
                                    pcount_reg <= pcount_reg + CNT_W'(1);
                                    status_reg <= ST_QUEUED;
                                    state_reg  <= S_FINISH;
                                end
                            end
                            CMD_RETRY:
                            begin
                                status_reg <= ST_DONE;
                                state_reg  <= S_WALK;
                            end
                            default:
                            begin
                                status_reg  <= ST_DONE;
                                dropped_reg <= inhibit_reg;
                                inhibit_reg <= 1'b0;
                                state_reg   <= S_CLEAR;
                            end
                        endcase
                    end
                end

                // ident RAM read of the send slot is taken here and is ready in S_FETCH
                S_RD:
                begin
                    state_reg <= S_FETCH;
                end

                S_WALK:
                begin
                    if (walk_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (pend_reg[cur_idx])
                    begin
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end

                // a new frame pushes the held one out; last is only known at the end
                S_FETCH:
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_reg <= hold_reg;
                        end
                        hold_reg         <= frame_res;
                        hold_valid_reg   <= 1'b1;
                        inhibit_reg      <= sync_reg[cur_idx];
                        nothing_sent_reg <= 1'b0;
                        if (cmd_reg == CMD_RETRY)
                        begin
                            pend_reg[cur_idx] <= 1'b0;
                            pcount_reg <= pcount_reg - CNT_W'(1);
                            qfree_reg  <= qfree_reg - CNT_W'(1);
                            k_reg      <= k_reg + CNT_W'(1);
                            idx_reg    <= idx_reg + CNT_W'(1);
                            state_reg  <= S_WALK;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end

                S_CLEAR:
                begin
                    if (idx_reg >= n_used)
                    begin
                        if (dropped_reg)
                        begin
                            late_reg <= 1'b1;
                        end
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        if (pend_reg[cur_idx] && sync_reg[cur_idx])
                        begin
                            pend_reg[cur_idx] <= 1'b0;
                            if (pcount_reg != '0)
                            begin
                                pcount_reg <= pcount_reg - CNT_W'(1);
                            end
                            dropped_reg <= 1'b1;
                        end
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_reg <= final_res;
                        end
                        else
                        begin
                            out_reg <= plain_res;
                        end
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid     = out_valid_reg;
    assign frame_valid   = out_reg.frame_valid;
    assign out_slot      = out_reg.out_slot;
    assign out_ident     = out_reg.out_ident;
    assign status        = out_reg.status;
    assign pending_total = out_reg.pending_total;
    assign inhibit_flag  = out_reg.inhibit_flag;
    assign overflow_flag = out_reg.overflow_flag;
    assign late_flag     = out_reg.late_flag;
    assign last          = out_reg.last;

endmodule

>>> src/cts_checker.sv
// Port-level checks for the transmit slot scheduler, bound to the top level.
`include "can_tx_slot_retry_scheduler_defines.svh"

module cts_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_stall,
    input logic                        frame_valid,
    input logic [cts_pkg::SLOT_W-1:0]  out_slot,
    input logic [cts_pkg::IDENT_W-1:0] out_ident,
    input logic [1:0]                  status,
    input logic                        overflow_flag,
    input logic                        late_flag
);
    import cts_pkg::*;

    `CTS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(out_ident) && $stable(out_slot), "stalled result changed")
    `CTS_ASSERT_NOW(a_no_frame_zero, res_valid && !frame_valid, (out_slot == '0) && (out_ident == '0), "slot/ident set without a frame")
    `CTS_ASSERT_NOW(a_frame_done, res_valid && frame_valid, status == ST_DONE, "frame result with non-done status")
    `CTS_ASSERT_NEXT(a_sticky_flags, overflow_flag || late_flag, (overflow_flag || !$past(overflow_flag)) && (late_flag || !$past(late_flag)), "error flag dropped")

endmodule

bind can_tx_slot_retry_scheduler cts_checker u_cts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .frame_valid   (frame_valid),
    .out_slot      (out_slot),
    .out_ident     (out_ident),
    .status        (status),
    .overflow_flag (overflow_flag),
    .late_flag     (late_flag)
);

>>> test/can_tx_slot_retry_scheduler_checker.sv
// Checker for the transmit slot scheduler: mirrors the slot table and compares every answer.
`timescale 1ns / 100ps
module can_tx_slot_retry_scheduler_checker
    import cts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CNT_W-1:0]   cfg_wr_data,
    input  logic               item_valid,
    input  logic               item_stall,
    input  logic [1:0]         command,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [IDENT_W-1:0] frame_ident,
    input  logic               sync_mark,
    input  logic [CNT_W-1:0]   queue_free,
    input  logic               res_valid,
    input  logic               res_stall,
    input  logic               frame_valid,
    input  logic [SLOT_W-1:0]  out_slot,
    input  logic [IDENT_W-1:0] out_ident,
    input  logic [1:0]         status,
    input  logic [CNT_W-1:0]   pending_total,
    input  logic               inhibit_flag,
    input  logic               overflow_flag,
    input  logic               late_flag,
    input  logic               last,
    output int                 mismatches,
    output int                 outstanding,
    output int                 results_seen,
    output int                 frames_seen
);

    localparam int TABLE_DEPTH = 32;

    logic [IDENT_W-1:0] ident_tab [TABLE_DEPTH];
    logic               sync_tab  [TABLE_DEPTH];
    logic               pend_tab  [TABLE_DEPTH];
    logic [CNT_W-1:0]   pend_cnt;
    logic               inhibit_m;
    logic               none_sent;
    logic               ovf_m;
    logic               late_m;
    logic [CNT_W-1:0]   range_cfg;

    res_t scheduler_answers [$];
    int   fail_tally;
    int   results_tally;
    int   frames_tally;

    task automatic reset_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            ident_tab[i] = '0;
            sync_tab[i]  = 1'b0;
            pend_tab[i]  = 1'b0;
        end
        pend_cnt  = '0;
        inhibit_m = 1'b0;
        none_sent = 1'b1;
        ovf_m     = 1'b0;
        late_m    = 1'b0;
        range_cfg = MAX_SLOTS;
        scheduler_answers.delete();
    endtask

    function automatic void push_answer(input logic fv, input logic [SLOT_W-1:0] sl,
                                        input logic [IDENT_W-1:0] id, input logic [1:0] st);
        res_t r;
        r.frame_valid   = fv;
        r.out_slot      = sl;
        r.out_ident     = id;
        r.status        = st;
        r.pending_total = pend_cnt;
        r.inhibit_flag  = inhibit_m;
        r.overflow_flag = ovf_m;
        r.late_flag     = late_m;
        r.last          = 1'b0;
        scheduler_answers.push_back(r);
    endfunction

    task automatic run_slot_command(input logic [1:0] cmd, input logic [SLOT_W-1:0] sl,
                                    input logic [IDENT_W-1:0] id, input logic sy,
                                    input logic [CNT_W-1:0] qf_in);
        int   n;
        int   k;
        int   room;
        logic dropped;
        res_t r;
        n       = int'((range_cfg > MAX_SLOTS) ? MAX_SLOTS : range_cfg);
        room    = int'(qf_in);
        k       = 0;
        dropped = 1'b0;
        case (cmd)
            CMD_SETUP:
            begin
                if (sl >= n)
                    push_answer(1'b0, '0, '0, ST_BAD);
                else
                begin
                    ident_tab[sl] = id;
                    sync_tab[sl]  = sy;
                    if (pend_tab[sl] && pend_cnt > 0)
                        pend_cnt--;
                    pend_tab[sl] = 1'b0;
                    push_answer(1'b0, '0, '0, ST_DONE);
                end
            end
            CMD_SEND:
            begin
                if (sl >= n)
                    push_answer(1'b0, '0, '0, ST_BAD);
                else if (pend_tab[sl])
                begin
                    // overflow only counts once something has gone out
                    if (!none_sent)
                        ovf_m = 1'b1;
                    push_answer(1'b0, '0, '0, ST_OVF);
                end
                else if (pend_cnt == 0 && room > 0)
                begin
                    inhibit_m = sync_tab[sl];
                    none_sent = 1'b0;
                    push_answer(1'b1, sl, ident_tab[sl], ST_DONE);
                end
                else
                begin
                    pend_tab[sl] = 1'b1;
                    pend_cnt++;
                    push_answer(1'b0, '0, '0, ST_QUEUED);
                end
            end
            CMD_RETRY:
            begin
                // marks beyond the range stay counted, so the count alone does not end the walk
                for (int i = 0; i < n && pend_cnt > 0; i++)
                begin
                    if (pend_tab[i])
                    begin
                        if (room == 0 || k >= MAX_RES)
                            break;
                        room--;
                        pend_tab[i] = 1'b0;
                        pend_cnt--;
                        inhibit_m = sync_tab[i];
                        none_sent = 1'b0;
                        push_answer(1'b1, SLOT_W'(i), ident_tab[i], ST_DONE);
                        k++;
                    end
                end
                if (k == 0)
                    push_answer(1'b0, '0, '0, ST_DONE);
            end
            CMD_CLEAR:
            begin
                if (inhibit_m)
                begin
                    inhibit_m = 1'b0;
                    dropped   = 1'b1;
                end
                for (int i = 0; i < n; i++)
                begin
                    if (pend_tab[i] && sync_tab[i])
                    begin
                        pend_tab[i] = 1'b0;
                        if (pend_cnt > 0)
                            pend_cnt--;
                        dropped = 1'b1;
                    end
                end
                if (dropped)
                    late_m = 1'b1;
                push_answer(1'b0, '0, '0, ST_DONE);
            end
        endcase
        r      = scheduler_answers.pop_back();
        r.last = 1'b1;
        scheduler_answers.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want)
        begin
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, fname, want, seen);
            fail_tally++;
        end
    endtask

    task automatic check_answer();
        res_t want;
        if (scheduler_answers.size() == 0)
        begin
            $display("%0t unrequested result: expected none, actual slot %0d ident %0d status %0d",
                     $time, out_slot, out_ident, status);
            fail_tally++;
        end
        else
        begin
            want = scheduler_answers.pop_front();
            check_field("frame_valid", 16'(want.frame_valid), 16'(frame_valid));
            check_field("out_slot", 16'(want.out_slot), 16'(out_slot));
            check_field("out_ident", 16'(want.out_ident), 16'(out_ident));
            check_field("status", 16'(want.status), 16'(status));
            check_field("pending_total", 16'(want.pending_total), 16'(pending_total));
            check_field("inhibit_flag", 16'(want.inhibit_flag), 16'(inhibit_flag));
            check_field("overflow_flag", 16'(want.overflow_flag), 16'(overflow_flag));
            check_field("late_flag", 16'(want.late_flag), 16'(late_flag));
            check_field("last", 16'(want.last), 16'(last));
            results_tally++;
            if (want.frame_valid)
                frames_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_table();
            fail_tally    = 0;
            results_tally = 0;
            frames_tally  = 0;
            mismatches   <= 0;
            outstanding  <= 0;
            results_seen <= 0;
            frames_seen  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                range_cfg = cfg_wr_data;
            if (item_valid && !item_stall)
                run_slot_command(command, slot, frame_ident, sync_mark, queue_free);
            if (res_valid && !res_stall)
                check_answer();
            mismatches   <= fail_tally;
            outstanding  <= scheduler_answers.size();
            results_seen <= results_tally;
            frames_seen  <= frames_tally;
        end
    end

endmodule

>>> test/can_tx_slot_retry_scheduler_tb.sv
// Testbench top for the transmit slot scheduler: drives requests, stalls results, gives the verdict.
`timescale 1ns / 100ps
module can_tx_slot_retry_scheduler_tb;

    import cts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 60;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]   cfg_wr_data = '0;
    logic               item_valid  = 1'b0;
    logic               item_stall;
    logic [1:0]         command     = CMD_SETUP;
    logic [SLOT_W-1:0]  slot        = '0;
    logic [IDENT_W-1:0] frame_ident = '0;
    logic               sync_mark   = 1'b0;
    logic [CNT_W-1:0]   queue_free  = '0;
    logic               res_valid;
    logic               res_stall   = 1'b0;
    logic               frame_valid;
    logic [SLOT_W-1:0]  out_slot;
    logic [IDENT_W-1:0] out_ident;
    logic [1:0]         status;
    logic [CNT_W-1:0]   pending_total;
    logic               inhibit_flag;
    logic               overflow_flag;
    logic               late_flag;
    logic               last;

    int mismatches;
    int outstanding;
    int results_seen;
    int frames_seen;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int items_sent   = 0;
    int used_range   = 32;
    int quiet_cycles = 0;
    int phase_range [6] = '{32, 5, 63, 1, 17, 32};

    can_tx_slot_retry_scheduler uut (.*);

    can_tx_slot_retry_scheduler_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        res_stall <= ($urandom_range(0, 99) < stall_pct);

    // counts cycles with no accepted request and no accepted result
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic issue(input logic [1:0] cmd, input logic [SLOT_W-1:0] sl,
                         input logic [IDENT_W-1:0] id, input logic sy,
                         input logic [CNT_W-1:0] qf);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        slot        <= sl;
        frame_ident <= id;
        sync_mark   <= sy;
        queue_free  <= qf;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // lets the checker count the last request before waiting for outstanding results to reach zero
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_range(input int v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        used_range = (v > 32) ? 32 : v;
    endtask

    function automatic logic [CNT_W-1:0] pick_room();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return '0;
        else if (r < 7)
            return CNT_W'($urandom_range(1, 4));
        else
            return CNT_W'($urandom_range(0, 32));
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 9) < 8)
            return SLOT_W'($urandom_range(0, used_range - 1));
        else
            return SLOT_W'($urandom_range(0, 31));
    endfunction

    initial
    begin
        int start;
        int pick;
        int burst_len;
        logic [SLOT_W-1:0] burst_slot [4];

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_gap_pct = 6;
        stall_pct    = 73;
        issue(CMD_SEND, 5'd3, '0, 1'b0, 6'd0);          // queued before anything went out
        issue(CMD_SEND, 5'd3, '0, 1'b0, 6'd5);          // already pending, overflow stays low
        issue(CMD_RETRY, '0, '0, 1'b0, 6'd0);           // no room: plain answer
        issue(CMD_SETUP, 5'd0, 11'h7FF, 1'b1, 6'd0);
        issue(CMD_SETUP, 5'd31, 11'h555, 1'b0, 6'd32);
        issue(CMD_SETUP, 5'd3, 11'h2AA, 1'b1, 6'd0);    // set up drops the pending mark
        issue(CMD_SEND, 5'd0, '0, 1'b0, 6'd32);         // straight out, inhibit follows sync
        issue(CMD_SEND, 5'd31, 11'h7FF, 1'b1, 6'd1);
        issue(CMD_SEND, 5'd0, '0, 1'b0, 6'd0);
        issue(CMD_SEND, 5'd3, '0, 1'b0, 6'd0);
        issue(CMD_SEND, 5'd31, '0, 1'b0, 6'd0);
        issue(CMD_SEND, 5'd0, '0, 1'b0, 6'd3);          // overflow now sticks
        issue(CMD_RETRY, '0, '0, 1'b0, 6'd1);           // one place: slot 0 only
        issue(CMD_CLEAR, '0, '0, 1'b0, 6'd0);           // drops the sync slot and inhibit
        issue(CMD_RETRY, 5'd31, 11'h7FF, 1'b1, 6'd32);
        issue(CMD_CLEAR, 5'd31, 11'h7FF, 1'b1, 6'd32);
        issue(CMD_RETRY, '0, '0, 1'b0, 6'd32);          // nothing pending
        issue(CMD_SEND, 5'd20, '0, 1'b0, 6'd0);         // stays pending across the shrink
        set_range(1);
        issue(CMD_SETUP, 5'd0, 11'h123, 1'b0, 6'd0);
        issue(CMD_SETUP, 5'd1, 11'h456, 1'b1, 6'd0);    // bad slot
        issue(CMD_SEND, 5'd31, '0, 1'b0, 6'd32);        // bad slot
        issue(CMD_SEND, 5'd0, '0, 1'b0, 6'd32);         // queued behind slot 20
        issue(CMD_RETRY, '0, '0, 1'b0, 6'd32);          // walk stops at the range
        set_range(63);
        issue(CMD_RETRY, '0, '0, 1'b0, 6'd32);          // slot 20 reached again

        for (int ph = 0; ph < 6; ph++)
        begin
            set_range(phase_range[ph]);
            case (ph / 2)
                0:
                begin
                    send_gap_pct = 6;
                    stall_pct    = 73;
                end
                1:
                begin
                    send_gap_pct = 73;
                    stall_pct    = 6;
                end
                default:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
            endcase
            start = items_sent;
            if (used_range == 32)
            begin
                // every slot pending, then one retry moves all of them out
                for (int s = 0; s < 32; s++)
                    issue(CMD_SEND, SLOT_W'(s), IDENT_W'($urandom_range(0, 2047)),
                          1'($urandom_range(0, 1)), 6'd0);
                issue(CMD_RETRY, '0, '0, 1'b0, 6'd32);
            end
            while (items_sent - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    burst_len = $urandom_range(1, 4);
                    for (int j = 0; j < burst_len; j++)
                    begin
                        burst_slot[j] = pick_slot();
                        issue(CMD_SETUP, burst_slot[j], IDENT_W'($urandom_range(0, 2047)),
                              1'($urandom_range(0, 1)), pick_room());
                        issue(CMD_SEND, burst_slot[j], IDENT_W'($urandom_range(0, 2047)),
                              1'($urandom_range(0, 1)),
                              ($urandom_range(0, 2) == 0) ? pick_room() : 6'd0);
                    end
                    if ($urandom_range(0, 3) == 0)
                        issue(CMD_SEND, burst_slot[0], IDENT_W'($urandom_range(0, 2047)),
                              1'($urandom_range(0, 1)), pick_room());
                    if ($urandom_range(0, 4) == 0)
                        issue(CMD_CLEAR, SLOT_W'($urandom_range(0, 31)),
                              IDENT_W'($urandom_range(0, 2047)),
                              1'($urandom_range(0, 1)), pick_room());
                    else
                        issue(CMD_RETRY, SLOT_W'($urandom_range(0, 31)),
                              IDENT_W'($urandom_range(0, 2047)),
                              1'($urandom_range(0, 1)),
                              CNT_W'($urandom_range(0, burst_len + 1)));
                end
                else
                    issue(2'($urandom_range(0, 3)), pick_slot(),
                          IDENT_W'($urandom_range(0, 2047)),
                          1'($urandom_range(0, 1)), pick_room());
            end
        end

        drain();
        repeat (200) @(posedge clk);

        $display("%0d requests sent, %0d results checked, %0d frames handed out",
                 items_sent, results_seen, frames_seen);
        $display("slot ranges 1 to 32 plus an oversized setting, under three idle profiles");
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
